// ----- src/cia_pkg.sv -----
package cia_pkg;

    localparam int WIDTH_DEF = 32;
    localparam int OP_W      = 3;
    localparam int ERR_W     = 2;

    // Fixed pipeline around the divider: input register, operand prep, output register.
    localparam int FRONT_STAGES = 2;
    localparam int BACK_STAGES  = 1;

    // Compute stages inside the multiplier lane before its delay line.
    localparam int MUL_STAGES = 4;

    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_REM = 3'd4;

    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_OVER    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_UNDER   = 2'd2;
    localparam logic [ERR_W-1:0] ERR_DIVZERO = 2'd3;

endpackage

// ----- src/cia_if.sv -----
interface cia_req_if
    import cia_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic signed [WIDTH-1:0] operand_a;
    logic signed [WIDTH-1:0] operand_b;

    modport source (output valid, operation, operand_a, operand_b, input ready);
    modport sink   (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface cia_res_if
    import cia_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] result;
    logic [ERR_W-1:0]        error_code;

    modport source (output valid, result, error_code, input ready);
    modport sink   (input valid, result, error_code, output ready);
endinterface

// ----- src/checked_int32_alu_core.sv -----
// Channel | Direction | Payload                            | Beat when
// i_req   | in        | operation, operand_a, operand_b    | valid && ready
// o_res   | out       | result, error_code                 | valid && ready
//
// One beat per cycle in and out. Every operation passes the input register,
// operand prep, the divider stages and the output register in turn, and its
// output beat follows from there. The divider sets the depth, because
// it resolves one quotient bit per stage. Add, subtract and multiply ride the
// same pipeline. Reset clears only the valid bits. When the output register
// holds a beat that is not taken, the whole pipeline holds and i_req.ready
// drops. Bubbles still advance while the output register is empty.
module checked_int32_alu_core
    import cia_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    cia_req_if.sink   i_req,
    cia_res_if.source o_res
);

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [ERR_W-1:0] err;
        logic [WIDTH-1:0] sum;
        logic             neg;
        logic             a_neg;
    } t_tag;

    logic en;

    logic             r_o_valid;
    logic [WIDTH-1:0] r_o_result;
    logic [ERR_W-1:0] r_o_error;

    assign en          = !r_o_valid || o_res.ready;
    assign i_req.ready = en;

    // Input register.
    logic             r_f_valid;
    logic [OP_W-1:0]  r_f_op;
    logic [WIDTH-1:0] r_f_a, r_f_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_op <= i_req.operation;
            r_f_a  <= i_req.operand_a;
            r_f_b  <= i_req.operand_b;
        end
    end

    // Operand prep: magnitudes, signs, add/subtract and the divide checks.
    localparam logic [WIDTH-1:0] VMIN = {1'b1, {(WIDTH-1){1'b0}}};

    t_tag             n_g_tag;
    logic [WIDTH-1:0] n_g_ma, n_g_mb;
    logic [WIDTH:0]   ext_a, ext_b, sum;

    always_comb begin
        ext_a  = {r_f_a[WIDTH-1], r_f_a};
        ext_b  = {r_f_b[WIDTH-1], r_f_b};
        sum    = (r_f_op == OP_SUB) ? ext_a - ext_b : ext_a + ext_b;
        n_g_ma = r_f_a[WIDTH-1] ? WIDTH'(-r_f_a) : r_f_a;
        n_g_mb = r_f_b[WIDTH-1] ? WIDTH'(-r_f_b) : r_f_b;

        n_g_tag.op    = r_f_op;
        n_g_tag.sum   = sum[WIDTH-1:0];
        n_g_tag.neg   = r_f_a[WIDTH-1] ^ r_f_b[WIDTH-1];
        n_g_tag.a_neg = r_f_a[WIDTH-1];
        n_g_tag.err   = ERR_NONE;
        case (r_f_op) inside
            OP_ADD, OP_SUB: begin
                // The exact sum needs WIDTH+1 bits; its sign tells which way it left.
                if (sum[WIDTH] != sum[WIDTH-1]) begin
                    n_g_tag.err = sum[WIDTH] ? ERR_UNDER : ERR_OVER;
                end
            end
            OP_DIV, OP_REM: begin
                if (r_f_b == '0) begin
                    n_g_tag.err = ERR_DIVZERO;
                end else if (r_f_op == OP_DIV && r_f_a == VMIN && r_f_b == '1) begin
                    n_g_tag.err = ERR_OVER;
                end
            end
            default: begin
            end
        endcase
    end

    logic             r_g_valid;
    t_tag             r_g_tag;
    logic [WIDTH-1:0] r_g_ma, r_g_mb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else if (en) begin
            r_g_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_tag <= n_g_tag;
            r_g_ma  <= n_g_ma;
            r_g_mb  <= n_g_mb;
        end
    end

    // Divider and multiplier lanes of equal depth.
    logic             d_valid;
    t_tag             d_tag;
    logic [WIDTH-1:0] d_quo, d_rem;
    logic [WIDTH-1:0] m_mag;
    logic [ERR_W-1:0] m_err;

    cia_div #(
        .WIDTH (WIDTH),
        .t_tag (t_tag)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_g_valid),
        .i_tag   (r_g_tag),
        .i_mag_a (r_g_ma),
        .i_mag_b (r_g_mb),
        .o_valid (d_valid),
        .o_tag   (d_tag),
        .o_quo   (d_quo),
        .o_rem   (d_rem)
    );

    cia_mul #(
        .WIDTH (WIDTH),
        .DEPTH (WIDTH)
    ) u_mul (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_mag_a (r_g_ma),
        .i_mag_b (r_g_mb),
        .i_neg   (r_g_tag.neg),
        .o_mag   (m_mag),
        .o_err   (m_err)
    );

    // Result select, sign and error masking.
    logic [WIDTH-1:0] n_o_result, mag;
    logic [ERR_W-1:0] n_o_error;
    logic             sgn;

    always_comb begin
        mag       = '0;
        sgn       = 1'b0;
        n_o_error = d_tag.err;
        unique case (d_tag.op)
            OP_ADD, OP_SUB: begin
                mag = d_tag.sum;
            end
            OP_MUL: begin
                mag       = m_mag;
                sgn       = d_tag.neg;
                n_o_error = m_err;
            end
            OP_DIV: begin
                mag = d_quo;
                sgn = d_tag.neg;
            end
            OP_REM: begin
                mag = d_rem;
                sgn = d_tag.a_neg;
            end
            default: begin
                n_o_error = ERR_NONE;
            end
        endcase
        n_o_result = sgn ? WIDTH'(-mag) : mag;
        if (n_o_error != ERR_NONE) begin
            n_o_result = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_result <= n_o_result;
            r_o_error  <= n_o_error;
        end
    end

    assign o_res.valid      = r_o_valid;
    assign o_res.result     = r_o_result;
    assign o_res.error_code = r_o_error;

endmodule

// ----- src/cia_mul.sv -----
module cia_mul
    import cia_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF,
    parameter int DEPTH = WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_mag_a,
    input  logic [WIDTH-1:0] i_mag_b,
    input  logic             i_neg,
    output logic [WIDTH-1:0] o_mag,
    output logic [ERR_W-1:0] o_err
);

    localparam int H      = (WIDTH + 1) / 2;
    localparam int HW     = WIDTH - H;
    localparam int P_W    = 2 * WIDTH;
    localparam int DELAY  = DEPTH - MUL_STAGES;

    logic [H-1:0]  a_lo, b_lo;
    logic [HW-1:0] a_hi, b_hi;

    assign a_lo = i_mag_a[H-1:0];
    assign a_hi = i_mag_a[WIDTH-1:H];
    assign b_lo = i_mag_b[H-1:0];
    assign b_hi = i_mag_b[WIDTH-1:H];

    // Stage 1: four half-width partial products.
    logic [2*H-1:0]   r_ll;
    logic [WIDTH-1:0] r_lh, r_hl;
    logic [2*HW-1:0]  r_hh;
    logic             r_neg1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll   <= (2*H)'(a_lo) * (2*H)'(b_lo);
            r_lh   <= WIDTH'(a_lo) * WIDTH'(b_hi);
            r_hl   <= WIDTH'(a_hi) * WIDTH'(b_lo);
            r_hh   <= (2*HW)'(a_hi) * (2*HW)'(b_hi);
            r_neg1 <= i_neg;
        end
    end

    // Stage 2: cross terms summed.
    logic [WIDTH:0]  r_mid;
    logic [2*H-1:0]  r_ll2;
    logic [2*HW-1:0] r_hh2;
    logic            r_neg2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mid  <= {1'b0, r_lh} + {1'b0, r_hl};
            r_ll2  <= r_ll;
            r_hh2  <= r_hh;
            r_neg2 <= r_neg1;
        end
    end

    // Stage 3: the outer products do not overlap, so they concatenate.
    logic [P_W-1:0] r_prod;
    logic           r_neg3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= {r_hh2, r_ll2} + (P_W'(r_mid) << H);
            r_neg3 <= r_neg2;
        end
    end

    // Stage 4: range check on the full product.
    logic             big, exact_min;
    logic [ERR_W-1:0] n_err4;
    logic [WIDTH-1:0] r_mag4;
    logic [ERR_W-1:0] r_err4;

    always_comb begin
        big       = |r_prod[P_W-1:WIDTH-1];
        exact_min = (r_prod[P_W-1:WIDTH-1] == (WIDTH+1)'(1)) && (r_prod[WIDTH-2:0] == '0);
        n_err4    = ERR_NONE;
        if (big) begin
            if (!r_neg3) begin
                n_err4 = ERR_OVER;
            end else if (!exact_min) begin
                n_err4 = ERR_UNDER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag4 <= r_prod[WIDTH-1:0];
            r_err4 <= n_err4;
        end
    end

    // Delay line so that this lane lines up with the divider.
    logic [WIDTH-1:0] r_dly_mag [DELAY];
    logic [ERR_W-1:0] r_dly_err [DELAY];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dly_mag[0] <= r_mag4;
            r_dly_err[0] <= r_err4;
            for (int k = 1; k < DELAY; k++) begin
                r_dly_mag[k] <= r_dly_mag[k-1];
                r_dly_err[k] <= r_dly_err[k-1];
            end
        end
    end

    assign o_mag = r_dly_mag[DELAY-1];
    assign o_err = r_dly_err[DELAY-1];

endmodule

// ----- src/cia_div.sv -----
module cia_div
    import cia_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF,
    parameter type t_tag = logic
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_tag             i_tag,
    input  logic [WIDTH-1:0] i_mag_a,
    input  logic [WIDTH-1:0] i_mag_b,
    output logic             o_valid,
    output t_tag             o_tag,
    output logic [WIDTH-1:0] o_quo,
    output logic [WIDTH-1:0] o_rem
);

    localparam int DEPTH = WIDTH;

    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rem [DEPTH];
    logic [WIDTH-1:0] r_quo [DEPTH];
    logic [WIDTH-1:0] r_div [DEPTH];
    t_tag             r_tag [DEPTH];

    logic [WIDTH-1:0] n_rem [DEPTH];
    logic [WIDTH-1:0] n_quo [DEPTH];
    logic [WIDTH-1:0] n_div [DEPTH];
    t_tag             n_tag [DEPTH];

    // Restoring division, one quotient bit per stage. The dividend shifts out
    // of the quotient register into the partial remainder from the top.
    always_comb begin
        logic [WIDTH-1:0] prev_rem, prev_quo;
        logic [WIDTH:0]   shifted, divisor;
        logic             ge;
        for (int k = 0; k < DEPTH; k++) begin
            prev_rem = (k == 0) ? '0 : r_rem[k-1];
            prev_quo = (k == 0) ? i_mag_a : r_quo[k-1];
            n_div[k] = (k == 0) ? i_mag_b : r_div[k-1];
            n_tag[k] = (k == 0) ? i_tag : r_tag[k-1];
            shifted  = {prev_rem, prev_quo[WIDTH-1]};
            divisor  = {1'b0, n_div[k]};
            ge       = shifted >= divisor;
            n_rem[k] = ge ? WIDTH'(shifted - divisor) : WIDTH'(shifted);
            n_quo[k] = {prev_quo[WIDTH-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_div <= n_div;
            r_tag <= n_tag;
        end
    end

    assign o_valid = r_vld[DEPTH-1];
    assign o_tag   = r_tag[DEPTH-1];
    assign o_quo   = r_quo[DEPTH-1];
    assign o_rem   = r_rem[DEPTH-1];

endmodule

// ----- sim/tb_checked_int32_alu_core.sv -----
module tb_checked_int32_alu_core;
    import cia_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = WIDTH_DEF;
    localparam longint VAL_MAX = (longint'(1) <<< (W - 1)) - 1;
    localparam longint VAL_MIN = -VAL_MAX - 1;
    localparam logic signed [W-1:0] OPND_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] OPND_MIN = {1'b1, {(W-1){1'b0}}};
    localparam int RANDOM_PER_PHASE = 100;
    localparam int LONG_HOLD = 300;
    localparam int TAIL_CYCLES = W + 12;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic signed [W-1:0] result;
        logic [ERR_W-1:0]    error_code;
    } t_alu_outcome;

    // Keeps the outcomes that the accepted requests must produce, in order.
    class alu_result_checker;
        t_alu_outcome pending_results[$];
        int mismatches;
        int checked;
        int err_seen[4];

        // Works on the exact value in 64 bits and then judges the range.
        static function t_alu_outcome compute_outcome(logic [OP_W-1:0] op,
                                                      logic signed [W-1:0] a,
                                                      logic signed [W-1:0] b);
            longint sa;
            longint sb;
            longint exact;
            t_alu_outcome o;
            sa = a;
            sb = b;
            exact = 0;
            o.result = '0;
            o.error_code = ERR_NONE;
            case (op)
                OP_ADD: exact = sa + sb;
                OP_SUB: exact = sa - sb;
                OP_MUL: exact = sa * sb;
                OP_DIV: begin
                    if (sb == 0) o.error_code = ERR_DIVZERO;
                    else exact = sa / sb;
                end
                OP_REM: begin
                    if (sb == 0) o.error_code = ERR_DIVZERO;
                    else exact = sa % sb;
                end
                default: exact = 0;
            endcase
            if (o.error_code == ERR_NONE) begin
                if (exact > VAL_MAX) o.error_code = ERR_OVER;
                else if (exact < VAL_MIN) o.error_code = ERR_UNDER;
                else o.result = exact[W-1:0];
            end
            return o;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic signed [W-1:0] a,
                                   logic signed [W-1:0] b);
            pending_results.push_back(compute_outcome(op, a, b));
        endfunction

        function void check_result(logic signed [W-1:0] res, logic [ERR_W-1:0] err);
            t_alu_outcome exp_o;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %0d err %0d", $time, res, err);
                mismatches++;
                return;
            end
            exp_o = pending_results.pop_front();
            checked++;
            if (exp_o.result !== res || exp_o.error_code !== err) begin
                $display("%0t: mismatch, expected result %0d err %0d, got result %0d err %0d",
                         $time, exp_o.result, exp_o.error_code, res, err);
                mismatches++;
            end
            if (!$isunknown(err)) err_seen[err]++;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    cia_req_if #(.WIDTH(W)) req_if();
    cia_res_if #(.WIDTH(W)) res_if();

    checked_int32_alu_core #(.WIDTH(W)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_res  (res_if.source)
    );

    alu_result_checker board = new();
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int sent = 0;

    always #1 i_clk = ~i_clk;

    task automatic send_request(input logic [OP_W-1:0] op, input logic signed [W-1:0] a,
                                input logic signed [W-1:0] b);
        while ($urandom_range(99) < send_gap_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.operand_a <= a;
        req_if.operand_b <= b;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        board.note_request(op, a, b);
        sent++;
    endtask

    // Lowers valid at the step of the last beat, then waits for every result.
    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [W-1:0] pick_operand();
        logic signed [W-1:0] v;
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(6))
                    0: v = OPND_MIN;
                    1: v = OPND_MAX;
                    2: v = 0;
                    3: v = -1;
                    4: v = 1;
                    5: v = OPND_MIN + 1;
                    default: v = OPND_MAX - 1;
                endcase
            end
            1: v = $signed(W'($urandom_range(32))) - 16;
            2: begin
                v = $signed(W'(1)) <<< $urandom_range(W - 1);
                if ($urandom_range(1)) v = -v;
            end
            3: begin
                // Magnitudes near the square root of the range sit on the product limit.
                v = $signed(W'($urandom_range(50000, 30000)));
                if ($urandom_range(1)) v = -v;
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    initial begin
        int served;
        int stretch;
        served = 0;
        stretch = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
                board.check_result(res_if.result, res_if.error_code);
            if (hold_requests != served) begin
                served = hold_requests;
                stretch = LONG_HOLD;
            end
            if (stretch > 0) begin
                stretch--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles, %0d results outstanding",
                         $time, quiet, board.pending());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        logic [OP_W-1:0] op;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.operation = OP_ADD;
        req_if.operand_a = '0;
        req_if.operand_b = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Range limits of each operation, the division corners and the unused codes.
        send_request(OP_ADD, OPND_MAX, 1);
        send_request(OP_ADD, OPND_MIN, -1);
        send_request(OP_ADD, OPND_MAX, OPND_MIN);
        send_request(OP_SUB, OPND_MIN, 1);
        send_request(OP_SUB, OPND_MAX, -1);
        send_request(OP_SUB, 0, OPND_MIN);
        send_request(OP_SUB, -1, OPND_MIN);
        send_request(OP_MUL, OPND_MAX, 2);
        send_request(OP_MUL, OPND_MIN, -1);
        send_request(OP_MUL, OPND_MIN, 1);
        send_request(OP_MUL, OPND_MAX, -1);
        send_request(OP_MUL, OPND_MIN, 2);
        send_request(OP_MUL, 65536, 65536);
        send_request(OP_MUL, -65536, 32768);
        send_request(OP_MUL, 0, OPND_MIN);
        send_request(OP_DIV, OPND_MAX, 0);
        send_request(OP_REM, OPND_MIN, 0);
        send_request(OP_DIV, OPND_MIN, -1);
        send_request(OP_REM, OPND_MIN, -1);
        send_request(OP_DIV, -1, OPND_MIN);
        send_request(OP_DIV, 7, -2);
        send_request(OP_REM, -7, 2);
        send_request(3'd5, OPND_MAX, OPND_MIN);
        send_request(3'd6, -1, -1);
        send_request(3'd7, 0, 0);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 59; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 59; end
                default: begin send_gap_pct = 32; recv_stall_pct = 32; end
            endcase
            // The output side freezes while requests keep coming, so the pipe backs up.
            if (phase == 0) hold_requests++;
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                if ($urandom_range(15) == 0) op = OP_W'($urandom_range(7, 5));
                else op = OP_W'($urandom_range(4, 0));
                send_request(op, pick_operand(), pick_operand());
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests across corner cases, a long output hold and mixed gaps.",
                 sent);
        $display("Checked %0d results: %0d clean, %0d overflow, %0d underflow, %0d div-by-zero.",
                 board.checked, board.err_seen[0], board.err_seen[1], board.err_seen[2],
                 board.err_seen[3]);
        if (board.pending() != 0)
            $display("%0t: %0d expected results never arrived", $time, board.pending());
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- checked_int32_alu_core.f -----
src/cia_pkg.sv
src/cia_if.sv
src/cia_mul.sv
src/cia_div.sv
src/checked_int32_alu_core.sv
sim/tb_checked_int32_alu_core.sv
